[rtl/fee_pkg.sv]
// Package for the flash EEPROM emulation block: sizes, item and command codes,
// and the flash address helpers. Depends on nothing; used by the top level.
`default_nettype none
package fee_pkg;

  localparam int STORE_BYTES  = 1024;
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_COUNT   = 4;
  localparam int PAGE_STRIDE  = ((STORE_BYTES + 3) / 4) * 4;
  localparam int STORE_AW     = $clog2(STORE_BYTES);

  localparam logic [7:0] FLIP_MASK   = 8'hFF;
  localparam logic [7:0] HEADER_MARK = 8'hA9;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_FLUSH = 3'd2,
    KIND_PROBE = 3'd3,
    KIND_LOAD  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CMD_ACK     = 3'd0,
    CMD_READ    = 3'd1,
    CMD_ERASE   = 3'd2,
    CMD_PROGRAM = 3'd3,
    CMD_LOAD    = 3'd4
  } cmd_e;

  // Byte address of the first sector of the storage area.
  function automatic logic [23:0] sector_addr(input logic [11:0] base);
    return 24'(base) * 24'(SECTOR_BYTES);
  endfunction

  // Byte address of one page of the storage area.
  function automatic logic [23:0] page_addr(input logic [11:0] base,
                                            input logic [2:0]  page);
    return sector_addr(base) + 24'(page) * 24'(PAGE_STRIDE);
  endfunction

endpackage
`default_nettype wire

[rtl/flash_eeprom_emulation_top.sv]
// Top level of the flash EEPROM emulation block: command decode, flags and
// page tracking around the image store. Depends on fee_pkg and fee_ram.
//
// The block keeps the emulated EEPROM image, held inverted as it lies in
// flash, in one synchronous RAM. An item is transferred at a rising edge
// with start_i high and busy_o low. Every result appears on the result ports
// for exactly one cycle, flagged by result_valid_o, and must be taken then:
// the receiver has no way to stall it, and last_o marks the final result of
// an item. Reads and writes to valid addresses pass a read-modify-write state,
// as the image RAM has registered read data (a write reads the old byte,
// compares it and writes back). A flush that both erases the sector and
// programs a page gives two results, the program in the cycle after the erase.
// Other flushes, header probes, raw loads, bad addresses and unknown kinds are
// answered from the idle state. A probe that finds page 0 unmarked answers at
// once and then fills the image with 0xFF, one byte a cycle, keeping busy_o
// high until the last byte is written. The base sector register has its own
// write channel, which is always ready; write it only while the block is idle.
`default_nettype none
module flash_eeprom_emulation_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  input  wire logic [2:0]  page_index_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [2:0]       command_o,
  output logic [7:0]       read_value_o,
  output logic [23:0]      flash_address_o,
  output logic             last_o,
  output logic             bad_address_o
);

  localparam int AW = fee_pkg::STORE_AW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_PROG,
    ST_CLEAR
  } state_e;

  state_e        state_q, state_d;
  logic [2:0]    cur_page_q, cur_page_d;
  logic          modified_q, modified_d;
  logic          new_page_q, new_page_d;
  logic          scan_q, scan_d;
  logic [11:0]   base_q, base_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    data_q, data_d;
  logic          is_write_q, is_write_d;
  logic [AW-1:0] clr_q, clr_d;

  logic          valid_q, valid_d;
  logic [2:0]    cmd_q, cmd_d;
  logic [7:0]    rval_q, rval_d;
  logic [23:0]   faddr_q, faddr_d;
  logic          last_q, last_d;
  logic          bad_q, bad_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          accept;
  logic          bad_in;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign bad_in      = address_i >= 16'(fee_pkg::STORE_BYTES);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [3:0] next_page;
    logic       erase;
    logic       scanning;
    logic [7:0] new_val;

    next_page  = 4'd0;
    erase      = 1'b0;
    scanning   = 1'b0;
    new_val    = data_q ^ fee_pkg::FLIP_MASK;

    state_d    = state_q;
    cur_page_d = cur_page_q;
    modified_d = modified_q;
    new_page_d = new_page_q;
    scan_d     = scan_q;
    base_d     = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : base_q;
    addr_d     = addr_q;
    data_d     = data_q;
    is_write_d = is_write_q;
    clr_d      = clr_q;

    valid_d    = 1'b0;
    cmd_d      = fee_pkg::CMD_ACK;
    rval_d     = 8'h00;
    faddr_d    = 24'h000000;
    last_d     = 1'b1;
    bad_d      = 1'b0;

    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = address_i[AW-1:0];
    ram_wdata  = data_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d = address_i[AW-1:0];
          data_d = data_i;
          case (kind_i)
            fee_pkg::KIND_READ: begin
              if (bad_in) begin
                valid_d = 1'b1;
                cmd_d   = fee_pkg::CMD_READ;
                bad_d   = 1'b1;
              end else begin
                ram_re     = 1'b1;
                is_write_d = 1'b0;
                state_d    = ST_RMW;
              end
            end
            fee_pkg::KIND_WRITE: begin
              if (bad_in) begin
                valid_d = 1'b1;
                bad_d   = 1'b1;
              end else begin
                ram_re     = 1'b1;
                is_write_d = 1'b1;
                state_d    = ST_RMW;
              end
            end
            fee_pkg::KIND_FLUSH: begin
              next_page = {1'b0, cur_page_q};
              if (new_page_q) begin
                next_page = next_page + 4'd1;
                if (next_page >= 4'(fee_pkg::PAGE_COUNT)) begin
                  next_page = 4'd0;
                  erase     = 1'b1;
                end
              end
              cur_page_d = next_page[2:0];
              modified_d = 1'b0;
              new_page_d = 1'b0;
              valid_d    = 1'b1;
              if (erase) begin
                cmd_d   = fee_pkg::CMD_ERASE;
                faddr_d = fee_pkg::sector_addr(base_q);
                last_d  = !modified_q;
                if (modified_q) begin
                  state_d = ST_PROG;
                end
              end else if (modified_q) begin
                cmd_d   = fee_pkg::CMD_PROGRAM;
                faddr_d = fee_pkg::page_addr(base_q, next_page[2:0]);
              end
            end
            fee_pkg::KIND_PROBE: begin
              valid_d  = 1'b1;
              scanning = scan_q || (page_index_i == 3'd0);
              scan_d   = scanning;
              if (scanning && ({1'b0, page_index_i} < 4'(fee_pkg::PAGE_COUNT))) begin
                if (data_i == fee_pkg::HEADER_MARK) begin
                  cur_page_d = page_index_i;
                  if (page_index_i == 3'(fee_pkg::PAGE_COUNT - 1)) begin
                    scan_d  = 1'b0;
                    cmd_d   = fee_pkg::CMD_LOAD;
                    faddr_d = fee_pkg::page_addr(base_q, page_index_i);
                  end
                end else if (page_index_i == 3'd0) begin
                  // Blank storage: start from an erased image on a fresh page.
                  cur_page_d = 3'(fee_pkg::PAGE_COUNT);
                  modified_d = 1'b0;
                  new_page_d = 1'b1;
                  scan_d     = 1'b0;
                  clr_d      = '0;
                  state_d    = ST_CLEAR;
                end else begin
                  scan_d  = 1'b0;
                  cmd_d   = fee_pkg::CMD_LOAD;
                  faddr_d = fee_pkg::page_addr(base_q, cur_page_q);
                end
              end
            end
            fee_pkg::KIND_LOAD: begin
              valid_d = 1'b1;
              bad_d   = bad_in;
              ram_we  = !bad_in;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_RMW: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        if (is_write_q) begin
          // A changed byte marks the image dirty; any bit going back to one
          // in the inverted image cannot be programmed in place.
          if (ram_rdata != new_val) begin
            modified_d = 1'b1;
            if (((ram_rdata ^ new_val) & new_val) != 8'h00) begin
              new_page_d = 1'b1;
            end
          end
          ram_we    = 1'b1;
          ram_waddr = addr_q;
          ram_wdata = new_val;
        end else begin
          cmd_d  = fee_pkg::CMD_READ;
          rval_d = ram_rdata ^ fee_pkg::FLIP_MASK;
        end
      end
      ST_PROG: begin
        state_d = ST_IDLE;
        valid_d = 1'b1;
        cmd_d   = fee_pkg::CMD_PROGRAM;
        faddr_d = fee_pkg::page_addr(base_q, cur_page_q);
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = fee_pkg::FLIP_MASK;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(fee_pkg::STORE_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_page_q <= 3'd0;
      modified_q <= 1'b0;
      new_page_q <= 1'b0;
      scan_q     <= 1'b0;
      base_q     <= 12'd0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_page_q <= cur_page_d;
      modified_q <= modified_d;
      new_page_q <= new_page_d;
      scan_q     <= scan_d;
      base_q     <= base_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    data_q     <= data_d;
    is_write_q <= is_write_d;
    clr_q      <= clr_d;
    cmd_q      <= cmd_d;
    rval_q     <= rval_d;
    faddr_q    <= faddr_d;
    last_q     <= last_d;
    bad_q      <= bad_d;
  end

  fee_ram #(
    .DEPTH(fee_pkg::STORE_BYTES),
    .WIDTH(8),
    .AW   (AW)
  ) u_image (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(address_i[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o  = valid_q;
  assign command_o       = cmd_q;
  assign read_value_o    = rval_q;
  assign flash_address_o = faddr_q;
  assign last_o          = last_q;
  assign bad_address_o   = bad_q;

  // A result that is not the last of its item is always followed at once.
  a_nonlast_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("non-final result not followed by another result");

  // Only an erase precedes another result of the same item.
  a_nonlast_is_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> command_o == fee_pkg::CMD_ERASE)
    else $error("non-final result is not an erase");

  // The read-modify-write state is followed by idle and a valid result.
  a_rmw_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RMW |=> state_q == ST_IDLE && result_valid_o)
    else $error("read-modify-write did not finish with a result");

  // No result is produced while the clearing pass runs, but the probe's answer at its start.
  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR && $past(state_q == ST_CLEAR) |-> !result_valid_o)
    else $error("result produced during the clearing pass");

endmodule
`default_nettype wire

[rtl/fee_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; instantiated by the top level for the image store.
`default_nettype none
module fee_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
